// File: hw/rtl/thermal_fan_mode_controller_assert.svh
`ifndef THERMAL_FAN_MODE_CONTROLLER_ASSERT_SVH
`define THERMAL_FAN_MODE_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define TFMC_ASSERT_NOW(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFMC_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/tfmc_pkg.sv
package tfmc_pkg;

    localparam logic [2:0] OP_SAMPLE = 3'd0;
    localparam logic [2:0] OP_BUTTON = 3'd1;
    localparam logic [2:0] OP_ACK    = 3'd2;
    localparam logic [2:0] OP_REQ    = 3'd3;
    localparam logic [2:0] OP_SET    = 3'd4;
    localparam logic [2:0] OP_POT    = 3'd5;
    localparam logic [2:0] OP_STATUS = 3'd6;
    localparam logic [2:0] OP_TICK   = 3'd7;

    localparam logic [1:0] MODE_MAN = 2'd0;
    localparam logic [1:0] MODE_AUT = 2'd1;
    localparam logic [1:0] MODE_WRN = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_RAISED  = 3'd1;
    localparam logic [2:0] EV_CLEARED = 3'd2;
    localparam logic [2:0] EV_REMIND  = 3'd3;
    localparam logic [2:0] EV_REJECT  = 3'd4;

    localparam logic [1:0] REG_WARN_ON  = 2'd0;
    localparam logic [1:0] REG_WARN_OFF = 2'd1;
    localparam logic [1:0] REG_LOW_MAX  = 2'd2;
    localparam logic [1:0] REG_MID_MAX  = 2'd3;

    localparam logic [11:0] RST_WARN_ON  = 12'd3000;
    localparam logic [11:0] RST_WARN_OFF = 12'd2800;
    localparam logic [11:0] RST_LOW_MAX  = 12'd1500;
    localparam logic [11:0] RST_MID_MAX  = 12'd2500;

    localparam logic [11:0] ADC_MAX  = 12'd4095;
    localparam logic [6:0]  PCT_FULL = 7'd100;
    localparam logic [6:0]  FAN_LOW  = 7'd30;
    localparam logic [6:0]  FAN_MID  = 7'd60;

    // s * 100 / 4095: quotient by 4096, then one correction step
    function automatic logic [6:0] pot_to_pct(input logic [11:0] s);
        logic [18:0] x;
        logic [6:0]  q0;
        logic [12:0] r;
        x  = 19'(s) * 19'd100;
        q0 = x[18:12];
        r  = {1'b0, x[11:0]} + 13'(q0);
        return (r >= {1'b0, ADC_MAX}) ? q0 + 7'd1 : q0;
    endfunction

endpackage

// File: hw/rtl/tfmc_if.sv
interface tfmc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [11:0] pot_sample;
    logic [11:0] temp_sample;
    logic        wanted_mode;
    logic [6:0]  speed_value;

    modport source (output valid, op, pot_sample, temp_sample, wanted_mode, speed_value,
                    input ready);
    modport sink   (input valid, op, pot_sample, temp_sample, wanted_mode, speed_value,
                    output ready);
endinterface

interface tfmc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode_now;
    logic [6:0]  fan_percent;
    logic        override_on;
    logic [6:0]  pot_percent;
    logic [11:0] temp_level;
    logic [2:0]  event_res;

    modport source (output valid, mode_now, fan_percent, override_on, pot_percent,
                    temp_level, event_res, input ready);
    modport sink   (input valid, mode_now, fan_percent, override_on, pot_percent,
                    temp_level, event_res, output ready);
endinterface

interface tfmc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/thermal_fan_mode_controller.sv
// Fan mode controller: one result item per input item, in order. An item passes an
// input register and is evaluated in a single pass into the result register, so a new
// item is taken every cycle while the result side keeps up; the result register is
// loaded from the input register once the result side can take the item. Configuration
// writes take effect on the next cycle and the config channel is always ready.
module thermal_fan_mode_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfmc_in_if.sink    i_in,
    tfmc_out_if.source o_out,
    tfmc_cfg_if.sink   i_cfg
);

    logic [11:0] r_warn_on, r_warn_off, r_low_max, r_mid_max;

    logic        r_in_valid;
    logic [2:0]  r_in_op;
    logic [11:0] r_in_pot;
    logic [11:0] r_in_temp;
    logic        r_in_want;
    logic [6:0]  r_in_spd;

    logic [1:0]  r_mode, n_mode;
    logic        r_req, n_req;
    logic [6:0]  r_pot_pct, n_pot_pct;
    logic [11:0] r_temp, n_temp;
    logic        r_ovr, n_ovr;
    logic [6:0]  r_man, n_man;
    logic [6:0]  r_fan, n_fan;
    logic [2:0]  n_ev;
    logic        w_apply;
    logic [6:0]  w_fan_calc;
    logic        w_warn;
    logic        w_adv;

    logic        r_out_valid;
    logic [2:0]  r_out_ev;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_on  <= tfmc_pkg::RST_WARN_ON;
            r_warn_off <= tfmc_pkg::RST_WARN_OFF;
            r_low_max  <= tfmc_pkg::RST_LOW_MAX;
            r_mid_max  <= tfmc_pkg::RST_MID_MAX;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tfmc_pkg::REG_WARN_ON:  r_warn_on  <= i_cfg.data;
                tfmc_pkg::REG_WARN_OFF: r_warn_off <= i_cfg.data;
                tfmc_pkg::REG_LOW_MAX:  r_low_max  <= i_cfg.data;
                tfmc_pkg::REG_MID_MAX:  r_mid_max  <= i_cfg.data;
            endcase
        end
    end

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op   <= i_in.op;
            r_in_pot  <= i_in.pot_sample;
            r_in_temp <= i_in.temp_sample;
            r_in_want <= i_in.wanted_mode;
            r_in_spd  <= i_in.speed_value;
        end
    end

    assign w_warn = (r_mode == tfmc_pkg::MODE_WRN);

    always_comb begin
        n_mode    = r_mode;
        n_req     = r_req;
        n_pot_pct = r_pot_pct;
        n_temp    = r_temp;
        n_ovr     = r_ovr;
        n_man     = r_man;
        n_ev      = tfmc_pkg::EV_NONE;
        w_apply   = 1'b0;
        unique case (r_in_op)
            tfmc_pkg::OP_SAMPLE: begin
                n_pot_pct = tfmc_pkg::pot_to_pct(r_in_pot);
                n_temp    = r_in_temp;
                if (!w_warn) begin
                    if (r_in_temp >= r_warn_on) begin
                        n_mode = tfmc_pkg::MODE_WRN;
                        n_ev   = tfmc_pkg::EV_RAISED;
                    end else begin
                        n_mode = {1'b0, r_req};
                    end
                    w_apply = 1'b1;
                end
            end
            tfmc_pkg::OP_BUTTON: begin
                if (!w_warn) begin
                    n_req   = (r_mode == tfmc_pkg::MODE_MAN);
                    n_mode  = {1'b0, n_req};
                    w_apply = 1'b1;
                end
            end
            tfmc_pkg::OP_ACK: begin
                if (w_warn && r_temp < r_warn_off) begin
                    n_mode  = {1'b0, r_req};
                    n_ev    = tfmc_pkg::EV_CLEARED;
                    w_apply = 1'b1;
                end
            end
            tfmc_pkg::OP_REQ: begin
                n_req = r_in_want;
                if (!w_warn) begin
                    n_mode  = {1'b0, r_in_want};
                    w_apply = 1'b1;
                end
            end
            tfmc_pkg::OP_SET: begin
                if (r_in_spd > tfmc_pkg::PCT_FULL) begin
                    n_ev = tfmc_pkg::EV_REJECT;
                end else begin
                    n_ovr   = 1'b1;
                    n_man   = r_in_spd;
                    w_apply = (r_mode == tfmc_pkg::MODE_MAN);
                end
            end
            tfmc_pkg::OP_POT: begin
                n_ovr   = 1'b0;
                w_apply = (r_mode == tfmc_pkg::MODE_MAN);
            end
            tfmc_pkg::OP_STATUS: begin
            end
            tfmc_pkg::OP_TICK: begin
                if (w_warn) begin
                    n_ev = tfmc_pkg::EV_REMIND;
                end
            end
        endcase
    end

    always_comb begin
        priority if (n_mode == tfmc_pkg::MODE_WRN) begin
            w_fan_calc = tfmc_pkg::PCT_FULL;
        end else if (n_mode == tfmc_pkg::MODE_MAN) begin
            w_fan_calc = n_ovr ? n_man : n_pot_pct;
        end else if (n_temp <= r_low_max) begin
            w_fan_calc = tfmc_pkg::FAN_LOW;
        end else if (n_temp <= r_mid_max) begin
            w_fan_calc = tfmc_pkg::FAN_MID;
        end else begin
            w_fan_calc = tfmc_pkg::PCT_FULL;
        end
    end

    assign n_fan = w_apply ? w_fan_calc : r_fan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= tfmc_pkg::MODE_MAN;
            r_req     <= 1'b0;
            r_pot_pct <= 7'd0;
            r_temp    <= 12'd0;
            r_ovr     <= 1'b0;
            r_man     <= 7'd0;
            r_fan     <= 7'd0;
        end else if (w_adv) begin
            r_mode    <= n_mode;
            r_req     <= n_req;
            r_pot_pct <= n_pot_pct;
            r_temp    <= n_temp;
            r_ovr     <= n_ovr;
            r_man     <= n_man;
            r_fan     <= n_fan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_ev <= n_ev;
        end
    end

    // result fields mirror the state registers, which only move with the result
    assign o_out.valid       = r_out_valid;
    assign o_out.mode_now    = r_mode;
    assign o_out.fan_percent = r_fan;
    assign o_out.override_on = r_ovr;
    assign o_out.pot_percent = r_pot_pct;
    assign o_out.temp_level  = r_temp;
    assign o_out.event_res   = r_out_ev;

endmodule

// File: hw/rtl/tfmc_checker.sv
`include "thermal_fan_mode_controller_assert.svh"

module tfmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_mode_now,
    input logic [6:0]  i_fan_percent,
    input logic        i_override_on,
    input logic [6:0]  i_pot_percent,
    input logic [11:0] i_temp_level,
    input logic [2:0]  i_event_res
);

    `TFMC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_mode_now, i_fan_percent, i_override_on, i_pot_percent, i_temp_level, i_event_res}), "result item changed while stalled")
    `TFMC_ASSERT_NOW(a_warn_full, i_clk, i_rst_n, i_out_valid && i_mode_now == tfmc_pkg::MODE_WRN, i_fan_percent == tfmc_pkg::PCT_FULL, "warning without full fan")
    `TFMC_ASSERT_NOW(a_raise_mode, i_clk, i_rst_n, i_out_valid && (i_event_res == tfmc_pkg::EV_RAISED || i_event_res == tfmc_pkg::EV_REMIND), i_mode_now == tfmc_pkg::MODE_WRN, "warning event outside warning")
    `TFMC_ASSERT_NOW(a_clear_mode, i_clk, i_rst_n, i_out_valid && i_event_res == tfmc_pkg::EV_CLEARED, i_mode_now != tfmc_pkg::MODE_WRN, "cleared event in warning")
    `TFMC_ASSERT_NOW(a_pct_range, i_clk, i_rst_n, i_out_valid, i_fan_percent <= tfmc_pkg::PCT_FULL && i_pot_percent <= tfmc_pkg::PCT_FULL, "percent above full")

endmodule

bind thermal_fan_mode_controller tfmc_checker u_tfmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_mode_now    (o_out.mode_now),
    .i_fan_percent (o_out.fan_percent),
    .i_override_on (o_out.override_on),
    .i_pot_percent (o_out.pot_percent),
    .i_temp_level  (o_out.temp_level),
    .i_event_res   (o_out.event_res)
);
